>>> rtl/core/plrl_pkg.sv
package plrl_pkg;

    localparam int MaxPointsDefault = 16;
    localparam int NumChannels      = 4;
    localparam int CoordW           = 12;
    localparam int CountW           = 5;
    localparam int CfgAddrW         = 2;
    localparam int CfgDataW         = 5;
    localparam int OneFixed         = 4080;

    localparam logic CmdWrite  = 1'b0;
    localparam logic CmdLookup = 1'b1;

    localparam logic [CfgAddrW-1:0] RegRedCount   = 2'd0;
    localparam logic [CfgAddrW-1:0] RegGreenCount = 2'd1;
    localparam logic [CfgAddrW-1:0] RegBlueCount  = 2'd2;
    localparam logic [CfgAddrW-1:0] RegAlphaCount = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  channel;
        logic [3:0]  slot;
        logic [11:0] point_x;
        logic [11:0] point_y;
        logic [7:0]  lookup_index;
    } t_req;

    typedef struct packed {
        logic [7:0] index_echo;
        logic [7:0] red_byte;
        logic [7:0] green_byte;
        logic [7:0] blue_byte;
        logic [7:0] alpha_byte;
    } t_rsp;

    // divider request/result between the sequencer and the divide unit
    typedef struct packed {
        logic        start;
        logic [23:0] num;
        logic [12:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [23:0] quo;
    } t_div_rsp;

endpackage

>>> rtl/core/piecewise_linear_rgba_lut.sv
// Piecewise-linear RGBA lookup table. Four channels of up to MAX_POINTS
// sorted control points sit in two point memories (x and y, one entry per
// channel and slot, registered read). A write request (cmd 0) stores
// one point in the cycle it is accepted and gives no result; the next request
// can follow at once. A write to a slot at or beyond MAX_POINTS is dropped.
// A lookup request (cmd 1) handles the channels one after another: an empty
// channel gives 0; x at or before the first point, or at or beyond the last,
// gives that point's y; otherwise the first and last points are read, then
// one memory read per segment searched (up to count - 1), a multiply and the
// serial 24-bit divide (skipped for a zero-width segment) give the value, and
// a final step moves on to the next channel. Lookup length is set by the
// single memory read port and the shared divider. The result sits in an
// output register, so new requests are taken while it waits for the receiver.
// After reset, the first two slots of each channel are loaded with (0,0) and
// (4080,4080) by a sweep before the first request is taken. Counts above
// MAX_POINTS are treated as MAX_POINTS.
module piecewise_linear_rgba_lut #(
    parameter int MAX_POINTS = plrl_pkg::MaxPointsDefault
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  plrl_pkg::t_req                   i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output plrl_pkg::t_rsp                   o_data,
    input  logic                             i_cfg_we,
    input  logic [plrl_pkg::CfgAddrW-1:0]    i_cfg_addr,
    input  logic [plrl_pkg::CfgDataW-1:0]    i_cfg_data
);
    import plrl_pkg::*;

    localparam int SlotW  = $clog2(MAX_POINTS);
    localparam int Depth  = NumChannels * (1 << SlotW);
    localparam int AddrW  = $clog2(Depth);
    localparam int InitW  = 3;

    localparam logic [3:0] StInit  = 4'd0;
    localparam logic [3:0] StIdle  = 4'd1;
    localparam logic [3:0] StChan  = 4'd2;
    localparam logic [3:0] StFirst = 4'd3;
    localparam logic [3:0] StLast  = 4'd4;
    localparam logic [3:0] StPair  = 4'd6;
    localparam logic [3:0] StMul   = 4'd7;
    localparam logic [3:0] StDiv   = 4'd8;
    localparam logic [3:0] StOut   = 4'd9;
    localparam logic [3:0] StRead  = 4'd10;

    logic [3:0] r_state, n_state;
    logic [CountW-1:0] r_count [NumChannels];
    logic [InitW-1:0] r_init, n_init;
    logic [1:0] r_ch, n_ch;
    logic [SlotW:0] r_i, n_i;
    logic [SlotW:0] r_n, n_n;
    logic [11:0] r_x, n_x;
    logic [11:0] r_x0, n_x0;
    logic [11:0] r_y0, n_y0;
    logic [11:0] r_x1, n_x1;
    logic [11:0] r_y1, n_y1;
    logic r_rd_y, n_rd_y;
    logic [7:0] r_idx, n_idx;
    logic [11:0] r_val [NumChannels];
    logic [11:0] n_val;
    logic n_val_we;
    logic r_neg, n_neg;
    logic [23:0] r_prod, n_prod;
    logic r_ovalid, n_ovalid;
    logic n_out_we;
    t_rsp r_odata, n_odata;

    logic mem_we;
    logic [AddrW-1:0] mem_waddr, mem_raddr;
    logic [11:0] mem_wx, mem_wy, rd_x, rd_y;
    t_div_req div_req;
    t_div_rsp div_rsp;

    plrl_ram #(.Width(CoordW), .Depth(Depth)) u_xram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wx),
        .i_raddr(mem_raddr), .o_rdata(rd_x));
    plrl_ram #(.Width(CoordW), .Depth(Depth)) u_yram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wy),
        .i_raddr(mem_raddr), .o_rdata(rd_y));
    plrl_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic accept;
    logic [CountW-1:0] cnt_raw;
    logic [SlotW:0] cnt_sat;
    logic [12:0] dx;
    logic [12:0] dy;
    logic [12:0] xo;
    logic [11:0] q12;

    assign o_stall = (r_state != StIdle);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        cnt_raw = r_count[r_ch];
        if (32'(cnt_raw) > MAX_POINTS) cnt_sat = (SlotW+1)'(MAX_POINTS);
        else                           cnt_sat = (SlotW+1)'(cnt_raw);
    end

    assign dx = {1'b0, r_x1} - {1'b0, r_x0};
    assign xo = {1'b0, r_x} - {1'b0, r_x0};
    assign q12 = div_rsp.quo[11:0];

    always_comb begin
        n_state  = r_state;
        n_init   = r_init;
        n_ch     = r_ch;
        n_i      = r_i;
        n_n      = r_n;
        n_x      = r_x;
        n_x0     = r_x0;
        n_y0     = r_y0;
        n_x1     = r_x1;
        n_y1     = r_y1;
        n_rd_y   = r_rd_y;
        n_idx    = r_idx;
        n_neg    = r_neg;
        n_prod   = r_prod;
        n_val    = '0;
        n_val_we = 1'b0;
        n_out_we = 1'b0;
        n_ovalid = r_ovalid && i_stall;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wx    = '0;
        mem_wy    = '0;
        mem_raddr = {r_ch, r_i[SlotW-1:0]};
        div_req   = '0;
        dy        = '0;
        case (r_state)
            // load default endpoints into each channel
            StInit: begin
                mem_we    = 1'b1;
                mem_waddr = {r_init[2:1], SlotW'(r_init[0])};
                mem_wx    = r_init[0] ? CoordW'(OneFixed) : '0;
                mem_wy    = mem_wx;
                n_init    = r_init + 1'b1;
                if (r_init == '1) n_state = StIdle;
            end
            StIdle: begin
                if (accept) begin
                    if (i_data.cmd == CmdWrite) begin
                        mem_we    = 32'(i_data.slot) < MAX_POINTS;
                        mem_waddr = {i_data.channel, SlotW'(i_data.slot)};
                        mem_wx    = i_data.point_x;
                        mem_wy    = i_data.point_y;
                    end else begin
                        n_idx   = i_data.lookup_index;
                        n_x     = {i_data.lookup_index, 4'b0};
                        n_ch    = '0;
                        n_state = StChan;
                    end
                end
            end
            // channel setup: read first point
            StChan: begin
                n_n = cnt_sat;
                n_i = '0;
                mem_raddr = {r_ch, SlotW'(0)};
                if (cnt_sat == '0) begin
                    n_val_we = 1'b1;
                    n_val    = '0;
                    n_state  = StOut;
                end else begin
                    n_state = StFirst;
                end
            end
            // first point arrives; request last point
            StFirst: begin
                mem_raddr = {r_ch, SlotW'(r_n - 1'b1)};
                if (r_x <= rd_x) begin
                    n_val_we = 1'b1;
                    n_val    = rd_y;
                    n_state  = StOut;
                end else begin
                    n_state = StLast;
                end
            end
            StLast: begin
                mem_raddr = {r_ch, SlotW'(0)};
                n_i = '0;
                if (r_x >= rd_x) begin
                    n_val_we = 1'b1;
                    n_val    = rd_y;
                    n_state  = StOut;
                end else begin
                    n_state = StRead;
                end
            end
            // slot 0 arrives: latch as x0 and fetch slot 1
            StRead: begin
                n_x0 = rd_x;
                n_y0 = rd_y;
                n_i = r_i + 1'b1;
                mem_raddr = {r_ch, SlotW'(r_i + 1'b1)};
                n_state = StPair;
            end
            // rd holds point i, the end of segment i-1
            StPair: begin
                n_x1 = rd_x;
                n_y1 = rd_y;
                if (r_x >= r_x0 && r_x <= rd_x) begin
                    n_state = StMul;
                end else if (r_i + 1'b1 >= r_n) begin
                    n_val_we = 1'b1;
                    n_val    = '0;
                    n_state  = StOut;
                end else begin
                    // next segment: current x1 becomes x0
                    n_x0 = rd_x;
                    n_y0 = rd_y;
                    n_i = r_i + 1'b1;
                    mem_raddr = {r_ch, SlotW'(r_i + 1'b1)};
                end
            end
            StMul: begin
                if (dx == '0) begin
                    n_val_we = 1'b1;
                    n_val    = r_y0;
                    n_state  = StOut;
                end else begin
                    n_neg = r_y1 < r_y0;
                    dy    = (r_y1 < r_y0) ? {1'b0, r_y0 - r_y1} : {1'b0, r_y1 - r_y0};
                    n_prod = xo[11:0] * dy[11:0];
                    n_state = StDiv;
                    n_rd_y  = 1'b1;
                end
            end
            StDiv: begin
                if (r_rd_y) begin
                    div_req.start = 1'b1;
                    div_req.num   = r_prod;
                    div_req.den   = dx;
                    n_rd_y = 1'b0;
                end else if (div_rsp.done) begin
                    n_val_we = 1'b1;
                    n_val    = r_neg ? r_y0 - q12 : r_y0 + q12;
                    n_state  = StOut;
                end
            end
            // advance to next channel, or hand the result to the output register
            StOut: begin
                if (r_ch == 2'd3) begin
                    if (!(r_ovalid && i_stall)) begin
                        n_ovalid = 1'b1;
                        n_out_we = 1'b1;
                        n_state  = StIdle;
                    end
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = StChan;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    // result assembled from the channel values
    always_comb begin
        n_odata.index_echo = r_idx;
        n_odata.red_byte   = r_val[0][11:4];
        n_odata.green_byte = r_val[1][11:4];
        n_odata.blue_byte  = r_val[2][11:4];
        n_odata.alpha_byte = r_val[3][11:4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StInit;
            r_init   <= '0;
            r_ovalid <= 1'b0;
            r_rd_y   <= 1'b0;
            for (int c = 0; c < NumChannels; c++) r_count[c] <= CountW'(2);
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_ovalid <= n_ovalid;
            r_rd_y   <= n_rd_y;
            if (i_cfg_we) r_count[i_cfg_addr] <= i_cfg_data;
        end
        r_ch   <= n_ch;
        r_i    <= n_i;
        r_n    <= n_n;
        r_x    <= n_x;
        r_x0   <= n_x0;
        r_y0   <= n_y0;
        r_x1   <= n_x1;
        r_y1   <= n_y1;
        r_idx  <= n_idx;
        r_neg  <= n_neg;
        r_prod <= n_prod;
        if (n_val_we) r_val[r_ch] <= n_val;
        if (n_out_we) r_odata <= n_odata;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
endmodule

>>> rtl/core/plrl_ram.sv
module plrl_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/plrl_div.sv
// Restoring divider, one quotient bit per cycle; magnitudes only.
module plrl_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plrl_pkg::t_div_req  i_req,
    output plrl_pkg::t_div_rsp  o_rsp
);
    import plrl_pkg::*;

    localparam int NumW = 24;
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] r_quo, n_quo;
    logic [12:0]     r_rem, n_rem;
    logic [12:0]     r_den, n_den;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [13:0]     trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[NumW-1]} - {1'b0, r_den};
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = CntW'(NumW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[13]) begin
                n_rem = trial[12:0];
                n_quo = {r_quo[NumW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[11:0], r_quo[NumW-1]};
                n_quo = {r_quo[NumW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
